[rtl/core/tari_pkg.sv]
// Package for the axis-aligned ray/triangle intersection block.
// Holds payload structs, widths and the queue record shared by all modules.
package tari_pkg;

  // Every value shares one fixed-point scale, so the fraction count does not
  // enter the arithmetic; only the coordinate width sizes the datapath.
  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int DW          = 2 * CW + 4;   // edge function width
  localparam int NW          = DW + CW + 2;  // weighted sum width
  localparam int QDEPTH      = 4;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  typedef struct packed {
    logic [1:0]           axis;
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] ray_u;
    logic signed [CW-1:0] ray_v;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_coord;
  } out_item_t;

  // Record handed from the classifying front to the dividing back.
  typedef struct packed {
    logic             hit;
    logic             neg;
    logic [NW-1:0]    num;  // magnitude of the weighted sum
    logic [DW-1:0]    den;  // positive weight sum
  } job_t;

endpackage

[rtl/core/tari_front.sv]
// Front: projects the triangle, forms the edge functions, classifies the hit
// and builds the numerator and denominator. Uses tari_pkg. Five stages.
module tari_front
  import tari_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  in_item_t in_item,
  output logic     job_vld,
  output job_t     job
);

  localparam int DF = CW + 1;
  localparam int LO = DW / 2;
  localparam int HI = DW - LO;

  logic [4:0] vld_r;
  // stage 1: projected differences
  logic signed [DF-1:0] du_r [3];
  logic signed [DF-1:0] dv_r [3];
  logic signed [CW-1:0] pa_r [3];
  logic                 bad_r;
  // stage 2: products
  logic signed [2*DF-1:0] m1_r [3];
  logic signed [2*DF-1:0] m2_r [3];
  logic signed [CW-1:0]   pa2_r [3];
  logic                   bad2_r;
  // stage 3: edge functions, sign normalised
  logic signed [DW-1:0] a_r [3];
  logic signed [CW-1:0] pa3_r [3];
  logic                 ok3_r;
  // stage 4: partial products of the weights with the axis coordinate
  logic signed [LO+CW:0]   pl_r [3];
  logic signed [HI+CW-1:0] ph_r [3];
  logic signed [DW-1:0]    a4_r [3];
  logic                    ok4_r;
  // stage 5: weighted coordinates
  logic signed [NW-1:0] w_r [3];
  logic signed [DW-1:0] a5_r [3];
  logic                 ok5_r;

  logic signed [CW-1:0] pu [3];
  logic signed [CW-1:0] pv [3];
  logic signed [CW-1:0] px [3];
  logic signed [CW-1:0] lu, lv;
  logic signed [DW-1:0] araw [3];
  logic signed [LO:0]   alo [3];
  logic signed [HI-1:0] ahi [3];
  logic                 anyp, anyn;
  logic signed [NW-1:0] num_s;
  logic signed [DW-1:0] den_s;

  always_comb begin
    lu = in_item.ray_u;
    lv = in_item.ray_v;
    unique case (axis_t'(in_item.axis))
      AXIS_X: begin
        pu = '{in_item.v0_y, in_item.v1_y, in_item.v2_y};
        pv = '{in_item.v0_z, in_item.v1_z, in_item.v2_z};
        px = '{in_item.v0_x, in_item.v1_x, in_item.v2_x};
      end
      AXIS_Y: begin
        pu = '{in_item.v0_z, in_item.v1_z, in_item.v2_z};
        pv = '{in_item.v0_x, in_item.v1_x, in_item.v2_x};
        px = '{in_item.v0_y, in_item.v1_y, in_item.v2_y};
        lu = in_item.ray_v;
        lv = in_item.ray_u;
      end
      default: begin
        pu = '{in_item.v0_x, in_item.v1_x, in_item.v2_x};
        pv = '{in_item.v0_y, in_item.v1_y, in_item.v2_y};
        px = '{in_item.v0_z, in_item.v1_z, in_item.v2_z};
      end
    endcase
  end

  always_comb begin
    anyp = 1'b0;
    anyn = 1'b0;
    for (int i = 0; i < 3; i++) begin
      araw[i] = DW'(m1_r[i]) - DW'(m2_r[i]);
      if (araw[i][DW-1]) anyn = 1'b1;
      else if (araw[i] != '0) anyp = 1'b1;
      // On a hit the normalised weight is never negative, so its upper half is a
      // nonnegative signed value and its lower half gets a zero sign bit.
      alo[i] = {1'b0, a_r[i][LO-1:0]};
      ahi[i] = a_r[i][DW-1:LO];
    end
    num_s = w_r[0] + w_r[1] + w_r[2];
    den_s = a5_r[0] + a5_r[1] + a5_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
    bad_r <= (in_item.axis == AXIS_BAD);
    for (int i = 0; i < 3; i++) begin
      du_r[i] <= DF'(pu[i]) - DF'(lu);
      dv_r[i] <= DF'(pv[i]) - DF'(lv);
      pa_r[i] <= px[i];
    end
    bad2_r <= bad_r;
    for (int i = 0; i < 3; i++) begin
      m1_r[i]  <= du_r[(i+1)%3] * dv_r[(i+2)%3];
      m2_r[i]  <= dv_r[(i+1)%3] * du_r[(i+2)%3];
      pa2_r[i] <= pa_r[i];
    end
    ok3_r <= !bad2_r && !(anyp && anyn) && (anyp || anyn);
    for (int i = 0; i < 3; i++) begin
      a_r[i]   <= anyn ? -araw[i] : araw[i];
      pa3_r[i] <= pa2_r[i];
    end
    // The weight times the coordinate is split into two half-width products.
    ok4_r <= ok3_r;
    for (int i = 0; i < 3; i++) begin
      pl_r[i] <= alo[i] * pa3_r[i];
      ph_r[i] <= ahi[i] * pa3_r[i];
      a4_r[i] <= a_r[i];
    end
    ok5_r <= ok4_r;
    for (int i = 0; i < 3; i++) begin
      w_r[i]  <= (NW'(ph_r[i]) <<< LO) + NW'(pl_r[i]);
      a5_r[i] <= a4_r[i];
    end
  end

  assign job_vld  = vld_r[4];
  assign job.hit  = ok5_r;
  assign job.neg  = num_s[NW-1];
  assign job.num  = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
  assign job.den  = den_s;

endmodule

[rtl/core/tari_queue.sv]
// Short queue between front and back; neither side stalls, and a job is read
// out whenever one is held. Uses tari_pkg for the job record.
module tari_queue
  import tari_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_vld,
  input  job_t wr_job,
  output logic rd_vld,
  output job_t rd_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          rd;

  assign rd     = cnt_r != '0;
  assign rd_vld = rd;
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_vld) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd)     rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_vld) - (AW+1)'(rd);
    end
    if (wr_vld) mem_r[wp_r] <= wr_job;
  end

endmodule

[rtl/core/tari_back.sv]
// Back: pipelined restoring divider, one quotient bit per stage, then
// saturation and sign. Uses tari_pkg.
module tari_back
  import tari_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_vld,
  input  job_t      job,
  output logic      out_vld,
  output out_item_t out_item
);

  localparam int QB = NW;

  logic          v_r   [QB+1];
  logic          h_r   [QB+1];
  logic          n_r   [QB+1];
  logic [NW-1:0] num_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic [DW:0]   rem_r [QB+1];
  logic          ov_r  [QB+1];

  logic          ov_vld_r;
  out_item_t     res_r;

  always_comb begin
    v_r[0]   = job_vld;
    h_r[0]   = job.hit;
    n_r[0]   = job.neg;
    num_r[0] = job.num;
    den_r[0] = job.den;
    rem_r[0] = '0;
    ov_r[0]  = 1'b0;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {rem_r[s], num_r[s][NW-1]};
    assign df = sh - {2'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else        v_r[s+1] <= v_r[s];
      h_r[s+1]   <= h_r[s];
      n_r[s+1]   <= n_r[s];
      den_r[s+1] <= den_r[s];
      if (!df[DW+1]) begin
        rem_r[s+1] <= df[DW:0];
        num_r[s+1] <= {num_r[s][NW-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= sh[DW:0];
        num_r[s+1] <= {num_r[s][NW-2:0], 1'b0};
      end
      // Quotient bits above the coordinate field force saturation.
      ov_r[s+1] <= ov_r[s] || (!df[DW+1] && (QB-1-s) >= CW);
    end
  end

  logic [CW-1:0] q, lim;
  always_comb begin
    q   = num_r[QB][CW-1:0];
    lim = n_r[QB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    if (ov_r[QB] || q > lim) q = lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_vld_r <= 1'b0;
    else        ov_vld_r <= v_r[QB];
    res_r.hit       <= h_r[QB];
    res_r.hit_coord <= h_r[QB] ? (n_r[QB] ? -q : q) : '0;
  end

  assign out_vld  = ov_vld_r;
  assign out_item = res_r;

endmodule

[rtl/core/triangle_axis_ray_intersect_top.sv]
// Axis-aligned line / triangle intersection, one transfer per clock.
// Pipeline: 5 front stages, the queue register, NW divider stages plus one output
// register. Throughput one item per cycle, busy stays low, and the result strobe
// cannot be stalled by the receiver.
// Reset (rst_n, synchronous, active low) clears all valid bits and pointers.
// Depends on tari_pkg, tari_front, tari_queue and tari_back.
module triangle_axis_ray_intersect_top
  import tari_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  // Every value shares one fixed-point scale, so the fraction count does not
  // alter the arithmetic; the coordinate width is fixed by the payload structs.
  logic acc;
  job_t fj, qj;
  logic fv, qv;

  // The pipeline takes a new transfer every cycle and never stalls.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Front classifies each transfer and builds the weighted sums.
  tari_front u_front (
    .clk, .rst_n, .in_vld(acc), .in_item, .job_vld(fv), .job(fj)
  );

  // The queue passes each job from the classifier to the divider pipeline.
  tari_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .wr_vld(fv), .wr_job(fj), .rd_vld(qv), .rd_job(qj)
  );

  // Back divides, saturates and signs the coordinate.
  tari_back u_back (
    .clk, .rst_n, .job_vld(qv), .job(qj), .out_vld(out_strobe), .out_item
  );

endmodule
